// ===== hdl/srlc_pkg.sv =====
package srlc_pkg;

  // line position and type counter widths
  localparam int POS_W = 10;
  localparam int CNT_W = 32;

  // decoupling queue between classifier and verdict stage
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // ascii codes
  localparam logic [7:0] CH_S  = 8'h53;
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_1  = 8'h31;
  localparam logic [7:0] CH_3  = 8'h33;
  localparam logic [7:0] CH_4  = 8'h34;
  localparam logic [7:0] CH_7  = 8'h37;
  localparam logic [7:0] CH_8  = 8'h38;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UF = 8'h46;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LF = 8'h66;

  // byte role codes
  localparam logic [1:0] ROLE_NONE = 2'd0;
  localparam logic [1:0] ROLE_ADDR = 2'd1;
  localparam logic [1:0] ROLE_DATA = 2'd2;

  // majority codes
  localparam logic [1:0] MAJ_NONE = 2'd0;
  localparam logic [1:0] MAJ_S1   = 2'd1;
  localparam logic [1:0] MAJ_S2   = 2'd2;
  localparam logic [1:0] MAJ_S3   = 2'd3;

  // classified character, front to back
  typedef struct packed {
    logic       file_start;
    logic       line_last;
    logic       long_line;
    logic       type_ok;
    logic       hex_ok;
    logic       count_ok;
    logic       sum_ok;
    logic [7:0] type_char;
    logic [1:0] role;
    logic [7:0] value;
  } srlc_evt_t;

  // one result word
  typedef struct packed {
    logic [1:0] role;
    logic [7:0] value;
    logic       line_done;
    logic       type_ok;
    logic       hex_ok;
    logic       count_ok;
    logic       sum_ok;
    logic       start_ok;
    logic       term_ok;
    logic [7:0] record_char;
    logic [1:0] maj;
  } srlc_res_t;

  function automatic logic is_upper_hex(input logic [7:0] c);
    return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_UA) && (c <= CH_UF));
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if ((c >= CH_0) && (c <= CH_9)) begin
      d = c - CH_0;
      return d[3:0];
    end else if ((c >= CH_UA) && (c <= CH_UF)) begin
      d = c - CH_UA;
      return d[3:0] + 4'd10;
    end else if ((c >= CH_LA) && (c <= CH_LF)) begin
      d = c - CH_LA;
      return d[3:0] + 4'd10;
    end
    return 4'd0;
  endfunction

  // address field length in bytes for a record type digit
  function automatic logic [2:0] addr_bytes(input logic [7:0] t);
    logic [2:0] n;
    case (t)
      8'h30, 8'h31, 8'h35, 8'h39: n = 3'd2;
      8'h32, 8'h36, 8'h38:        n = 3'd3;
      8'h33, 8'h37:               n = 3'd4;
      default:                    n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== hdl/srlc_front.sv =====
module srlc_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  acc,
  input  logic [7:0]            char_in,
  input  logic                  line_last,
  input  logic                  file_start,
  output srlc_pkg::srlc_evt_t   evt
);
  import srlc_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [3:0]       hi_nib_r, hi_nib_nxt;
  logic [7:0]       held_r, held_nxt;
  logic             held_v_r, held_v_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       count_r, count_nxt;
  logic [7:0]       type_r, type_nxt;
  logic             tflag_r, tflag_nxt;
  logic             hflag_r, hflag_nxt;

  logic [POS_W-1:0] pos_c, off, len, len_m4;
  logic [POS_W-2:0] pair;
  logic [3:0]       ab1;
  logic [7:0]       b;

  // classify the character against the line in progress
  always_comb begin
    pos_c      = file_start ? '0 : pos_r;
    hi_nib_nxt = file_start ? 4'd0 : hi_nib_r;
    held_nxt   = file_start ? 8'd0 : held_r;
    held_v_nxt = file_start ? 1'b0 : held_v_r;
    sum_nxt    = file_start ? 8'd0 : sum_r;
    count_nxt  = file_start ? 8'd0 : count_r;
    type_nxt   = file_start ? 8'd0 : type_r;
    tflag_nxt  = file_start ? 1'b1 : tflag_r;
    hflag_nxt  = file_start ? 1'b1 : hflag_r;

    off  = pos_c - POS_W'(2);
    pair = off[POS_W-1:1];
    ab1  = {1'b0, addr_bytes(type_nxt)} + 4'd1;
    b    = {hi_nib_nxt, nibble_of(char_in)};

    evt            = '0;
    evt.file_start = file_start;
    evt.line_last  = line_last;

    if (pos_c == '0) begin
      if (char_in != CH_S) tflag_nxt = 1'b0;
    end else if (pos_c == POS_W'(1)) begin
      type_nxt = char_in;
      if ((char_in < CH_0) || (char_in > CH_9) || (char_in == CH_4)) tflag_nxt = 1'b0;
    end else begin
      if (!is_upper_hex(char_in)) hflag_nxt = 1'b0;
      if (pos_c != POS_MAX) begin
        if (!off[0]) begin
          hi_nib_nxt = nibble_of(char_in);
        end else begin
          // release the previously held byte
          if (held_v_nxt) begin
            sum_nxt = sum_nxt + held_nxt;
            if (pair >= (POS_W-1)'(2)) begin
              evt.role  = (pair <= {{(POS_W-5){1'b0}}, ab1}) ? ROLE_ADDR : ROLE_DATA;
              evt.value = held_nxt;
            end
          end
          if (pair == '0) count_nxt = b;
          held_nxt   = b;
          held_v_nxt = 1'b1;
        end
      end
    end

    pos_nxt = (pos_c != POS_MAX) ? pos_c + POS_W'(1) : pos_c;
    len     = pos_nxt;
    len_m4  = len - POS_W'(4);

    // line verdict parts
    evt.long_line = (len >= POS_W'(4));
    evt.type_ok   = tflag_nxt;
    evt.hex_ok    = hflag_nxt;
    evt.type_char = type_nxt;
    evt.count_ok  = ({{(POS_W-8){1'b0}}, count_nxt} == {1'b0, len_m4[POS_W-1:1]});
    evt.sum_ok    = held_v_nxt && ((8'hFF - sum_nxt) == held_nxt);

    // line end clears the line state
    if (line_last) begin
      pos_nxt    = '0;
      hi_nib_nxt = 4'd0;
      held_nxt   = 8'd0;
      held_v_nxt = 1'b0;
      sum_nxt    = 8'd0;
      count_nxt  = 8'd0;
      type_nxt   = 8'd0;
      tflag_nxt  = 1'b1;
      hflag_nxt  = 1'b1;
    end
  end

  // line state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      hi_nib_r <= 4'd0;
      held_r   <= 8'd0;
      held_v_r <= 1'b0;
      sum_r    <= 8'd0;
      count_r  <= 8'd0;
      type_r   <= 8'd0;
      tflag_r  <= 1'b1;
      hflag_r  <= 1'b1;
    end else if (acc) begin
      pos_r    <= pos_nxt;
      hi_nib_r <= hi_nib_nxt;
      held_r   <= held_nxt;
      held_v_r <= held_v_nxt;
      sum_r    <= sum_nxt;
      count_r  <= count_nxt;
      type_r   <= type_nxt;
      tflag_r  <= tflag_nxt;
      hflag_r  <= hflag_nxt;
    end
  end

`ifndef ASSERT_OFF
  // a held byte exists only once the type and one full pair are in
  a_held_pos: assert property (@(posedge clk) disable iff (!rst_n)
    held_v_r |-> (pos_r >= POS_W'(4)))
    else $error("held byte without a complete pair");
`endif

endmodule

// ===== hdl/srlc_queue.sv =====
module srlc_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  srlc_pkg::srlc_evt_t   push_evt,
  output logic                  full,
  output logic                  head_valid,
  output srlc_pkg::srlc_evt_t   head,
  input  logic                  pop
);
  import srlc_pkg::*;

  srlc_evt_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full       = (count_r == (QPTR_W+1)'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + (QPTR_W+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_evt;
    end
  end

`ifndef ASSERT_OFF
  // a lone push grows the queue by one word
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + (QPTR_W+1)'(1)))
    else $error("queue count did not follow a push");
`endif

endmodule

// ===== hdl/srlc_back.sv =====
module srlc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  evt_valid,
  input  srlc_pkg::srlc_evt_t   evt,
  output logic                  evt_pop,
  output logic                  res_valid,
  output srlc_pkg::srlc_res_t   res,
  input  logic                  res_ready
);
  import srlc_pkg::*;

  logic [CNT_W-1:0] cnt_r   [3];
  logic [CNT_W-1:0] cnt_nxt [3];
  logic             expect_r, expect_nxt;
  logic             valid_r;
  srlc_res_t        res_r, res_nxt;

  logic [CNT_W-1:0] base [3];
  logic [7:0]       tdiff;
  logic             bump;
  logic [1:0]       maj;
  logic             term_ok;

  assign evt_pop   = evt_valid && (!valid_r || res_ready);
  assign res_valid = valid_r;
  assign res       = res_r;

  // type counters and majority
  always_comb begin
    tdiff = evt.type_char - CH_1;
    bump  = evt.line_last && evt.long_line &&
            (evt.type_char >= CH_1) && (evt.type_char <= CH_3);
    for (int i = 0; i < 3; i++) begin
      base[i]    = evt.file_start ? '0 : cnt_r[i];
      cnt_nxt[i] = base[i];
      if (bump && (tdiff[1:0] == 2'(i)) && (base[i] != CNT_MAX)) begin
        cnt_nxt[i] = base[i] + CNT_W'(1);
      end
    end
    if ((cnt_nxt[0] > cnt_nxt[1]) && (cnt_nxt[0] > cnt_nxt[2])) begin
      maj = MAJ_S1;
    end else if ((cnt_nxt[1] > cnt_nxt[0]) && (cnt_nxt[1] > cnt_nxt[2])) begin
      maj = MAJ_S2;
    end else if ((cnt_nxt[2] > cnt_nxt[0]) && (cnt_nxt[2] > cnt_nxt[1])) begin
      maj = MAJ_S3;
    end else begin
      maj = MAJ_NONE;
    end
  end

  // terminating record against the majority type
  always_comb begin
    case (evt.type_char)
      CH_9:    term_ok = (maj == MAJ_S1);
      CH_8:    term_ok = (maj == MAJ_S2);
      CH_7:    term_ok = (maj == MAJ_S3);
      default: term_ok = 1'b1;
    endcase
  end

  // result word
  always_comb begin
    expect_nxt    = evt.file_start || expect_r;
    res_nxt       = '0;
    res_nxt.role  = evt.role;
    res_nxt.value = evt.value;
    if (evt.line_last) begin
      res_nxt.line_done   = 1'b1;
      res_nxt.record_char = evt.type_char;
      res_nxt.maj         = maj;
      if (evt.long_line) begin
        res_nxt.type_ok  = evt.type_ok;
        res_nxt.hex_ok   = evt.hex_ok;
        res_nxt.count_ok = evt.count_ok;
        res_nxt.sum_ok   = evt.sum_ok;
        res_nxt.start_ok = expect_nxt ? (evt.type_ok && (evt.type_char == CH_0)) : 1'b1;
        res_nxt.term_ok  = term_ok;
      end
      expect_nxt = 1'b0;
    end
  end

  // counter and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) cnt_r[i] <= '0;
      expect_r <= 1'b1;
      valid_r  <= 1'b0;
    end else if (evt_pop) begin
      for (int i = 0; i < 3; i++) cnt_r[i] <= cnt_nxt[i];
      expect_r <= expect_nxt;
      valid_r  <= 1'b1;
    end else if (res_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_pop) begin
      res_r <= res_nxt;
    end
  end

`ifndef ASSERT_OFF
  // verdicts appear only on the line end word
  a_verdict_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !res_r.line_done) |->
      (!res_r.type_ok && !res_r.hex_ok && !res_r.count_ok && !res_r.sum_ok &&
       !res_r.start_ok && !res_r.term_ok && (res_r.record_char == 8'd0) &&
       (res_r.maj == MAJ_NONE)))
    else $error("verdict fields set off a line end");

  // no released byte means a zero value
  a_byte_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && (res_r.role == ROLE_NONE)) |-> (res_r.value == 8'd0))
    else $error("byte value without a byte role");

  // byte role is always one of the three defined codes
  a_role_code: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> ((res_r.role == ROLE_NONE) || (res_r.role == ROLE_ADDR) ||
                 (res_r.role == ROLE_DATA)))
    else $error("undefined byte role");
`endif

endmodule

// ===== hdl/srecord_line_checker.sv =====
// S-record line checker
// in_*: one character of a record line per word, line terminator removed.
//   in_tlast marks the last character of the line, in_tuser marks the first
//   character of a file (clears the S1/S2/S3 counts and expects an S0 line).
// out_*: exactly one word for every input word. out_tuser gives the role of
//   the byte released with that character (none, address, data) and
//   out_tdata[7:0] its value; bytes come out one hex pair late, so the
//   checksum pair is never released. out_tlast marks the line end word,
//   which carries the line verdicts, the record type character and the
//   majority data record type.
// Each accepted character goes into the queue, then into the output register
//   by the back stage. Throughput: one character per clock while the receiver is
//   ready; front classifier and back verdict stage each take one word per cycle.
// Reset clears the line state and the type counts; the next line is
//   expected to be S0 and in_tready is high from the first cycle after it.
// When the receiver stalls, the output register holds its word, the
//   two-word queue fills and in_tready drops until the output drains.
module srecord_line_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_in
  input  logic        in_tlast,   // line_last
  input  logic        in_tuser,   // file_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] byte_value, [8] type_ok, [9] hex_ok,
                                  // [10] count_ok, [11] sum_ok, [12] start_ok,
                                  // [13] terminate_ok, [21:14] record_char,
                                  // [23:22] majority_type
  output logic        out_tlast,  // line_done
  output logic [1:0]  out_tuser   // byte_role
);
  import srlc_pkg::*;

  srlc_evt_t front_evt;
  srlc_evt_t head_evt;
  srlc_res_t res;
  logic      push;
  logic      q_full;
  logic      head_valid;
  logic      pop;

  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;

  // classifier
  srlc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (push),
    .char_in    (in_tdata),
    .line_last  (in_tlast),
    .file_start (in_tuser),
    .evt        (front_evt)
  );

  // decoupling queue
  srlc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_evt   (front_evt),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head_evt),
    .pop        (pop)
  );

  // counters, verdicts and output register
  srlc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt_valid (head_valid),
    .evt       (head_evt),
    .evt_pop   (pop),
    .res_valid (out_tvalid),
    .res       (res),
    .res_ready (out_tready)
  );

  // output packing
  assign out_tdata = {res.maj, res.record_char, res.term_ok, res.start_ok,
                      res.sum_ok, res.count_ok, res.hex_ok, res.type_ok, res.value};
  assign out_tlast = res.line_done;
  assign out_tuser = res.role;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import srlc_pkg::*;

  localparam int RANDOM_CHARS = 850;
  localparam int IDLE_LIMIT   = 1000;

  // record type digits and hex letters not in the package
  localparam logic [7:0] DIG_2 = 8'h32;
  localparam logic [7:0] DIG_5 = 8'h35;
  localparam logic [7:0] DIG_6 = 8'h36;
  localparam logic [7:0] HEX_C = 8'h43;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       fs;
    logic       typed;
    srlc_res_t  res;
  } stim_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] char_in
  logic        in_tlast = 1'b0;    // line_last
  logic        in_tuser = 1'b0;    // file_start
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;          // [7:0] byte_value, [8] type_ok, [9] hex_ok,
                                   // [10] count_ok, [11] sum_ok, [12] start_ok,
                                   // [13] terminate_ok, [21:14] record_char,
                                   // [23:22] majority_type
  logic        out_tlast;          // line_done
  logic [1:0]  out_tuser;          // byte_role

  // line checker model state
  logic [POS_W-1:0] line_pos;
  logic [3:0]       upper_nib;
  logic [7:0]       held_val;
  logic             held_ok;
  logic [7:0]       byte_sum;
  logic [7:0]       count_val;
  logic [7:0]       rec_type;
  logic             type_good;
  logic             hex_good;
  logic [CNT_W-1:0] data_rec_count [3];
  logic             first_line;

  srlc_res_t  pending_words [$];
  srlc_res_t  seen_word;
  srlc_res_t  due_word;
  logic [7:0] line_chars [$];
  stim_row_t  dir_rows [24];

  int  fail_count = 0;
  int  chars_sent = 0;
  int  idle_cycles = 0;
  int  rx_hold = 0;
  int  rx_gap;
  logic quiet = 1'b0;

  srecord_line_checker DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, a few long ones, none while quiet
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic upper_hex(input logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UF);
  endfunction

  // lowercase still decodes, anything else reads as zero
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= CH_0 && c <= CH_9) d = c - CH_0;
    else if (c >= CH_UA && c <= CH_UF) d = c - CH_UA + 8'd10;
    else if (c >= CH_LA && c <= CH_LF) d = c - CH_LA + 8'd10;
    return d[3:0];
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? CH_0 + 8'(n) : CH_UA + 8'(n) - 8'd10;
  endfunction

  function automatic int addr_len(input logic [7:0] t);
    case (t)
      CH_0, CH_1, DIG_5, CH_9: return 2;
      DIG_2, DIG_6, CH_8:      return 3;
      CH_3, CH_7:              return 4;
      default:                 return 0;
    endcase
  endfunction

  // strict majority among the S1/S2/S3 counts
  function automatic logic [1:0] leading_type();
    logic [CNT_W-1:0] n1, n2, n3;
    n1 = data_rec_count[0];
    n2 = data_rec_count[1];
    n3 = data_rec_count[2];
    if (n1 > n2 && n1 > n3) return MAJ_S1;
    if (n2 > n1 && n2 > n3) return MAJ_S2;
    if (n3 > n1 && n3 > n2) return MAJ_S3;
    return MAJ_NONE;
  endfunction

  function automatic void drop_line();
    line_pos  = '0;
    upper_nib = 4'h0;
    held_val  = 8'h00;
    held_ok   = 1'b0;
    byte_sum  = 8'h00;
    count_val = 8'h00;
    rec_type  = 8'h00;
    type_good = 1'b1;
    hex_good  = 1'b1;
  endfunction

  // advances the line state by one character and returns the word it causes
  function automatic srlc_res_t decode_record_char(input logic [7:0] c, input logic last,
                                                   input logic fs);
    srlc_res_t   r;
    logic [7:0]  b;
    logic [7:0]  cks;
    int unsigned pos, pair, hop, len, slot;
    r = '0;
    if (fs) begin
      data_rec_count[0] = '0;
      data_rec_count[1] = '0;
      data_rec_count[2] = '0;
      first_line = 1'b1;
      drop_line();
    end
    pos = line_pos;
    if (pos == 0) begin
      if (c != CH_S) type_good = 1'b0;
    end else if (pos == 1) begin
      rec_type = c;
      if (c < CH_0 || c > CH_9 || c == CH_4) type_good = 1'b0;
    end else begin
      if (!upper_hex(c)) hex_good = 1'b0;
      // the saturated position is hex checked but never decoded
      if (pos < POS_MAX) begin
        if ((pos % 2) == 0) begin
          upper_nib = hex_nibble(c);
        end else begin
          b = {upper_nib, hex_nibble(c)};
          pair = (pos - 2) / 2;
          if (held_ok) begin
            hop = pair - 1;
            byte_sum = byte_sum + held_val;
            // the count byte is summed but not released
            if (hop >= 1) begin
              r.role  = (hop <= addr_len(rec_type)) ? ROLE_ADDR : ROLE_DATA;
              r.value = held_val;
            end
          end
          if (pair == 0) count_val = b;
          held_val = b;
          held_ok  = 1'b1;
        end
      end
    end
    if (pos < POS_MAX) line_pos = line_pos + 1'b1;

    // line verdicts
    if (last) begin
      len = line_pos;
      r.line_done   = 1'b1;
      r.record_char = rec_type;
      if (len >= 4) begin
        if (rec_type >= CH_1 && rec_type <= CH_3) begin
          slot = rec_type - CH_1;
          if (data_rec_count[slot] != CNT_MAX) data_rec_count[slot]++;
        end
        r.maj      = leading_type();
        r.type_ok  = type_good;
        r.hex_ok   = hex_good;
        r.count_ok = (count_val == (len - 4) / 2);
        cks        = 8'hFF - byte_sum;
        r.sum_ok   = held_ok && (cks == held_val);
        r.start_ok = first_line ? (type_good && rec_type == CH_0) : 1'b1;
        case (rec_type)
          CH_9:    r.term_ok = (r.maj == MAJ_S1);
          CH_8:    r.term_ok = (r.maj == MAJ_S2);
          CH_7:    r.term_ok = (r.maj == MAJ_S3);
          default: r.term_ok = 1'b1;
        endcase
      end else begin
        r.maj = leading_type();
      end
      drop_line();
      first_line = 1'b0;
    end
    return r;
  endfunction

  function automatic void add_hex_byte(input logic [7:0] b);
    line_chars.push_back(hex_char(b[7:4]));
    line_chars.push_back(hex_char(b[3:0]));
  endfunction

  // well-formed record with random address and data bytes
  function automatic void build_record(input logic [7:0] t, input int n_data);
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] cnt;
    int n_addr;
    n_addr = addr_len(t);
    cnt = 8'(n_addr + n_data + 1);
    line_chars.delete();
    line_chars.push_back(CH_S);
    line_chars.push_back(t);
    add_hex_byte(cnt);
    sum = cnt;
    repeat (n_addr + n_data) begin
      b = 8'($urandom);
      sum = sum + b;
      add_hex_byte(b);
    end
    add_hex_byte(8'hFF - sum);
  endfunction

  // one slip in an otherwise good record
  function automatic void damage_record();
    int idx;
    int keep;
    idx = $urandom_range(2, line_chars.size() - 1);
    keep = $urandom_range(1, 3);
    case ($urandom_range(0, 6))
      0: line_chars[idx] = hex_char(4'($urandom));
      1: line_chars[idx] = CH_LA + 8'($urandom_range(0, 5));
      2: line_chars[$urandom_range(0, line_chars.size() - 1)] = 8'($urandom);
      3: line_chars.delete(idx);
      4: line_chars.push_back(hex_char(4'($urandom)));
      5: line_chars[1] = ($urandom_range(0, 1) != 0) ? CH_4 : 8'($urandom);
      default: begin
        while (line_chars.size() > keep) line_chars.pop_back();
      end
    endcase
  endfunction

  function automatic void build_noise();
    int n;
    n = $urandom_range(1, 8);
    line_chars.delete();
    repeat (n) begin
      if ($urandom_range(0, 1) != 0) line_chars.push_back(8'($urandom));
      else line_chars.push_back(hex_char(4'($urandom)));
    end
    if ($urandom_range(0, 1) != 0) line_chars[0] = CH_S;
  endfunction

  // drive one character word and queue what it should produce
  task automatic send_char(input logic [7:0] c, input logic last, input logic fs,
                           input logic typed, input srlc_res_t typed_res);
    int gap;
    srlc_res_t r;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    in_tuser  <= fs;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = decode_record_char(c, last, fs);
    pending_words.push_back(typed ? typed_res : r);
    chars_sent++;
    @(negedge clk);
  endtask

  // a file start may land mid-line and drop what came before
  task automatic send_line(input logic new_file, input logic allow_cut);
    int cut;
    cut = -1;
    if (allow_cut && line_chars.size() > 1 && $urandom_range(0, 29) == 0)
      cut = $urandom_range(1, line_chars.size() - 1);
    foreach (line_chars[i])
      send_char(line_chars[i], i == line_chars.size() - 1, (i == 0 && new_file) || i == cut,
                1'b0, '0);
  endtask

  // receiver stalls
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) quiet <= !quiet;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_hold != 0) begin
      out_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      rx_gap = pick_gap();
      out_tready <= (rx_gap == 0);
      rx_hold <= (rx_gap == 0) ? 0 : rx_gap - 1;
    end
  end

  function automatic void match_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // result word check against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_word.role        = out_tuser;
      seen_word.value       = out_tdata[7:0];
      seen_word.line_done   = out_tlast;
      seen_word.type_ok     = out_tdata[8];
      seen_word.hex_ok      = out_tdata[9];
      seen_word.count_ok    = out_tdata[10];
      seen_word.sum_ok      = out_tdata[11];
      seen_word.start_ok    = out_tdata[12];
      seen_word.term_ok     = out_tdata[13];
      seen_word.record_char = out_tdata[21:14];
      seen_word.maj         = out_tdata[23:22];
      if (pending_words.size() == 0) begin
        $error("result word arrived with nothing expected");
        fail_count++;
      end else begin
        due_word = pending_words.pop_front();
        match_field("byte_role", due_word.role, seen_word.role);
        match_field("byte_value", due_word.value, seen_word.value);
        match_field("line_done", due_word.line_done, seen_word.line_done);
        match_field("type_ok", due_word.type_ok, seen_word.type_ok);
        match_field("hex_ok", due_word.hex_ok, seen_word.hex_ok);
        match_field("count_ok", due_word.count_ok, seen_word.count_ok);
        match_field("sum_ok", due_word.sum_ok, seen_word.sum_ok);
        match_field("start_ok", due_word.start_ok, seen_word.start_ok);
        match_field("terminate_ok", due_word.term_ok, seen_word.term_ok);
        match_field("record_char", due_word.record_char, seen_word.record_char);
        match_field("majority_type", due_word.maj, seen_word.maj);
      end
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int rand_start;
    int long_chars;
    int long_start;
    int file_no;
    int n_rec;
    int pick;
    int dom;
    logic [7:0] t;

    dir_rows = '{
      // short line right after reset: every verdict low
      '{CH_S,   1'b0, 1'b1, 1'b1, '0},
      '{CH_1,   1'b1, 1'b0, 1'b1,
        '{ROLE_NONE, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, CH_1, MAJ_NONE}},
      // S0 header, count 3, checksum FC
      '{CH_S,   1'b0, 1'b0, 1'b1, '0},
      '{CH_0,   1'b0, 1'b0, 1'b0, '0},
      '{CH_0,   1'b0, 1'b0, 1'b0, '0},
      '{CH_3,   1'b0, 1'b0, 1'b0, '0},
      '{CH_0,   1'b0, 1'b0, 1'b0, '0},
      '{CH_0,   1'b0, 1'b0, 1'b0, '0},
      '{CH_0,   1'b0, 1'b0, 1'b0, '0},
      '{CH_0,   1'b0, 1'b0, 1'b0, '0},
      '{CH_UF,  1'b0, 1'b0, 1'b0, '0},
      '{HEX_C,  1'b1, 1'b0, 1'b0, '0},
      // line cut short by a new file, then a junk line with lowercase hex
      '{CH_S,   1'b0, 1'b0, 1'b0, '0},
      '{CH_9,   1'b0, 1'b0, 1'b0, '0},
      '{CH_LA,  1'b0, 1'b0, 1'b0, '0},
      '{8'hFF,  1'b0, 1'b1, 1'b1, '0},
      '{8'h00,  1'b0, 1'b0, 1'b0, '0},
      '{CH_LF,  1'b0, 1'b0, 1'b0, '0},
      '{CH_4,   1'b1, 1'b0, 1'b1,
        '{ROLE_NONE, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00, MAJ_NONE}},
      // odd length, trailing character left unpaired
      '{CH_S,   1'b0, 1'b0, 1'b0, '0},
      '{DIG_5,  1'b0, 1'b0, 1'b0, '0},
      '{CH_0,   1'b0, 1'b0, 1'b0, '0},
      '{CH_3,   1'b0, 1'b0, 1'b0, '0},
      '{CH_0,   1'b1, 1'b0, 1'b0, '0}
    };

    drop_line();
    data_rec_count[0] = '0;
    data_rec_count[1] = '0;
    data_rec_count[2] = '0;
    first_line = 1'b1;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_char(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].fs, dir_rows[i].typed,
                dir_rows[i].res);

    // random files: header, data records around one dominant type, terminator
    rand_start = chars_sent;
    long_chars = 0;
    file_no = 0;
    while (chars_sent - rand_start - long_chars < RANDOM_CHARS) begin
      dom = $urandom_range(1, 3);
      if ($urandom_range(0, 9) != 0) build_record(CH_0, $urandom_range(0, 8));
      else build_noise();
      send_line(1'b1, 1'b1);

      // one overlong line runs the position into saturation
      if (file_no == 2) begin
        long_start = chars_sent;
        line_chars.delete();
        line_chars.push_back(CH_S);
        line_chars.push_back(CH_1);
        repeat (int'(POS_MAX) + $urandom_range(0, 6)) line_chars.push_back(hex_char(4'($urandom)));
        send_line(1'b0, 1'b0);
        long_chars += chars_sent - long_start;
      end

      n_rec = $urandom_range(1, 12);
      repeat (n_rec) begin
        pick = $urandom_range(0, 19);
        if (pick < 2) begin
          build_noise();
        end else begin
          if (pick == 2) t = DIG_5;
          else if (pick == 3) t = DIG_6;
          else if (pick < 8) t = CH_1 + 8'($urandom_range(0, 2));
          else t = CH_1 + 8'(dom - 1);
          if ($urandom_range(0, 4) == 0) build_record(t, $urandom_range(7, 32));
          else build_record(t, $urandom_range(0, 6));
          if ($urandom_range(0, 6) == 0) damage_record();
        end
        send_line(1'b0, 1'b1);
      end

      if ($urandom_range(0, 9) < 7) t = CH_9 - 8'(dom - 1);
      else t = CH_7 + 8'($urandom_range(0, 2));
      build_record(t, 0);
      if ($urandom_range(0, 6) == 0) damage_record();
      send_line(1'b0, 1'b1);
      file_no++;
    end

    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
